// ----- src/quadrature_encoder_speed_unit_defines.svh -----
// Assertion macros shared by the quadrature encoder speed unit.
`ifndef QUADRATURE_ENCODER_SPEED_UNIT_DEFINES_SVH
`define QUADRATURE_ENCODER_SPEED_UNIT_DEFINES_SVH

// Checks that a condition seen at one edge implies another at the same edge.
`define QES_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition seen at one edge implies another at the next edge.
`define QES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/qes_pkg.sv -----
// Shared types and constants of the quadrature encoder speed unit.
package qes_pkg;

	localparam int WINDOW_DEPTH = 8;
	localparam int IDX_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 2);
	localparam int TIME_W       = 32;
	localparam int SPEED_W      = 33;
	localparam int DIV_CNT_W    = $clog2(TIME_W);

	localparam logic [1:0] ACT_EDGE_A = 2'd0;
	localparam logic [1:0] ACT_EDGE_B = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_FWD  = 2'b01;
	localparam logic [1:0] DIR_BWD  = 2'b11;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // take the accepted item into the work registers
		logic edge_upd;  // apply the direction, counter and index update
		logic mem_read;  // read the period ring at the current index
		logic update;    // update the window sum and load the divider
		logic div_step;  // one quotient bit
		logic load_out;  // move the finished result into the output register
	} qes_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;  // the divider is on its last quotient bit
		logic out_valid; // the output register holds an untaken result
	} qes_sts_t;

endpackage

// ----- src/quadrature_encoder_speed_unit.sv -----
// Top level of the quadrature encoder speed unit.
`include "quadrature_encoder_speed_unit_defines.svh"

// Each input transaction is an edge on encoder channel A or B, or a speed query, and
// carries both pin levels and a microsecond timestamp; every input transaction produces
// exactly one output transaction with the current direction, the number of periods in
// the averaging window, the window sum and the signed speed, which is speed_numerator
// divided by the larger of the last stored period and the time since the last edge.
// An item passes through these steps in order: accept, the direction update, the
// period ring access and the window sum, the bit-per-cycle restoring divider that
// forms the speed, and the load of the output register once it is free. The output
// register lets the block accept the next item while the previous result is still
// waiting for m_tready. The speed_numerator register is written with cfg_we and
// cfg_data and should only change while no item is in flight.
module quadrature_encoder_speed_unit import qes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // level_a [0], level_b [1], now_us [33:2], zero [39:34]
	input  logic [1:0]  s_tuser,  // action [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // direction [1:0], window_count [5:2],
	                              // window_sum [37:6], speed [70:38], zero [71]
	input  logic        cfg_we,
	input  logic [31:0] cfg_data
);

	qes_cmd_t cmd;
	qes_sts_t sts;

	logic [1:0]         out_direction;
	logic [3:0]         out_window_count;
	logic [TIME_W-1:0]  out_window_sum;
	logic [SPEED_W-1:0] out_speed;

	// The controller sequences one item at a time through the datapath.
	qes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the window state, the period ring, the divider and the
	// output register.
	qes_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_action        (s_tuser),
		.in_level_a       (s_tdata[0]),
		.in_level_b       (s_tdata[1]),
		.in_now_us        (s_tdata[33:2]),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.m_tready         (m_tready),
		.m_tvalid         (m_tvalid),
		.out_direction    (out_direction),
		.out_window_count (out_window_count),
		.out_window_sum   (out_window_sum),
		.out_speed        (out_speed)
	);

	assign m_tdata = {1'b0, out_speed, out_window_sum, out_window_count, out_direction};

	// An accepted item keeps the block busy on the following cycle.
	`QES_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted twice in a row")
	// Loading the output register always raises the output valid.
	`QES_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, m_tvalid, "result load lost")
	// The divider stops stepping once it has produced its last quotient bit.
	`QES_ASSERT_NEXT(a_div_stops, cmd.div_step && sts.div_last, !cmd.div_step, "division overran")
	// A result is never loaded over one that is waiting and not being taken.
	`QES_ASSERT_SAME(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready, "result overwritten")

endmodule

// ----- src/qes_ctrl.sv -----
// Controller state machine of the quadrature encoder speed unit.
module qes_ctrl import qes_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     m_tready,
	input  qes_sts_t sts,
	output qes_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_READ,
		ST_UPDATE,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !sts.out_valid || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_EDGE;
				end
				ST_EDGE:   state_q <= ST_READ;
				ST_READ:   state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && s_tvalid;
		cmd.edge_upd = (state_q == ST_EDGE);
		cmd.mem_read = (state_q == ST_READ);
		cmd.update   = (state_q == ST_UPDATE);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_FINISH) && out_free;
	end

endmodule

// ----- src/qes_datapath.sv -----
// Datapath of the quadrature encoder speed unit: window state, period ring, divider, result.
module qes_datapath import qes_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  qes_cmd_t            cmd,
	output qes_sts_t            sts,
	input  logic [1:0]          in_action,
	input  logic                in_level_a,
	input  logic                in_level_b,
	input  logic [TIME_W-1:0]   in_now_us,
	input  logic                cfg_we,
	input  logic [TIME_W-1:0]   cfg_data,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [1:0]          out_direction,
	output logic [3:0]          out_window_count,
	output logic [TIME_W-1:0]   out_window_sum,
	output logic [SPEED_W-1:0]  out_speed
);

	logic [TIME_W-1:0] numerator_q;

	logic [1:0]        act_q;
	logic              la_q;
	logic              lb_q;
	logic [TIME_W-1:0] now_q;

	logic [TIME_W-1:0] last_q;
	logic [CNT_W-1:0]  counter_q;
	logic [IDX_W-1:0]  idx_q;
	logic [1:0]        dir_q;
	logic [TIME_W-1:0] sum_q;
	logic [TIME_W-1:0] period_q;
	logic              same_q;
	logic              sub_q;
	logic [TIME_W-1:0] rd_q;

	logic [TIME_W-1:0]       ring_q [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] ring_valid_q;

	logic [TIME_W-1:0]    divisor_q;
	logic [TIME_W-1:0]    quo_q;
	logic [TIME_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic              is_edge;
	logic              forward;
	logic [1:0]        new_dir;
	logic [IDX_W-1:0]  idx_next;
	logic [TIME_W-1:0] ring_val;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] t_max;
	logic [TIME_W-1:0] t_div;
	logic [TIME_W:0]   rem_shift;
	logic              rem_ge;
	logic [TIME_W-1:0] rem_next;
	logic [SPEED_W-1:0] q_ext;
	logic [SPEED_W-1:0] speed_val;
	logic [3:0]        count_val;

	assign is_edge  = (act_q == ACT_EDGE_A) || (act_q == ACT_EDGE_B);
	assign forward  = (act_q == ACT_EDGE_A) ? (la_q == lb_q) : (la_q != lb_q);
	assign new_dir  = forward ? DIR_FWD : DIR_BWD;
	assign idx_next = (idx_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : idx_q + 1'b1;

	// A same-direction edge has just stored its period at the current index.
	assign ring_val = same_q ? period_q : rd_q;
	assign elapsed  = now_q - last_q;
	assign t_max    = (elapsed > ring_val) ? elapsed : ring_val;
	assign t_div    = (t_max == '0) ? TIME_W'(1) : t_max;

	// Restoring division, one quotient bit per cycle.
	assign rem_shift = {rem_q, quo_q[TIME_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, divisor_q});
	assign rem_next  = rem_ge ? TIME_W'(rem_shift - {1'b0, divisor_q})
	                          : rem_shift[TIME_W-1:0];

	assign q_ext = {1'b0, quo_q};
	always_comb begin
		case (dir_q)
			DIR_FWD: speed_val = q_ext;
			DIR_BWD: speed_val = SPEED_W'(0) - q_ext;
			default: speed_val = '0;
		endcase
	end

	assign count_val = (counter_q == '0) ? 4'd0 : 4'(counter_q - 1'b1);

	assign sts.div_last  = (div_cnt_q == DIV_CNT_W'(TIME_W - 1));
	assign sts.out_valid = m_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q  <= '0;
			last_q       <= '0;
			counter_q    <= '0;
			idx_q        <= '0;
			dir_q        <= DIR_NONE;
			sum_q        <= '0;
			ring_valid_q <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			if (cfg_we) numerator_q <= cfg_data;
			if (cmd.edge_upd && is_edge) begin
				last_q <= now_q;
				if (new_dir != dir_q) begin
					counter_q <= CNT_W'(1);
					dir_q     <= new_dir;
					sum_q     <= '0;
				end else begin
					idx_q <= idx_next;
					if (counter_q <= CNT_W'(WINDOW_DEPTH)) counter_q <= counter_q + 1'b1;
				end
			end
			if (cmd.update && same_q) begin
				sum_q <= sum_q - (sub_q ? rd_q : '0) + period_q;
				ring_valid_q[idx_q] <= 1'b1;
			end
			if (cmd.load_out) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= in_action;
			la_q  <= in_level_a;
			lb_q  <= in_level_b;
			now_q <= in_now_us;
		end
		if (cmd.edge_upd) begin
			same_q   <= is_edge && (new_dir == dir_q);
			sub_q    <= (counter_q > CNT_W'(WINDOW_DEPTH));
			period_q <= now_q - last_q;
		end
		if (cmd.mem_read) rd_q <= ring_valid_q[idx_q] ? ring_q[idx_q] : '0;
		if (cmd.update && same_q) ring_q[idx_q] <= period_q;
		if (cmd.update) begin
			divisor_q <= t_div;
			quo_q     <= numerator_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= rem_next;
			quo_q     <= {quo_q[TIME_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (cmd.load_out) begin
			out_direction    <= dir_q;
			out_window_count <= count_val;
			out_window_sum   <= sum_q;
			out_speed        <= speed_val;
		end
	end

endmodule

// ----- test/quadrature_encoder_speed_unit_test.sv -----
// Self-checking testbench for the quadrature encoder speed unit.
module quadrature_encoder_speed_unit_test;
	import qes_pkg::*;

	// Action code 3 has no name in the package; the block treats it as a query.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// The slowest correct run is far below this, even with random idle gaps on each side of
	// every item and one long receiver hold-off.
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_REPORTS = 40;

	// One expected output transaction, one field per member.
	typedef struct packed {
		logic [1:0]         direction;
		logic [3:0]         window_count;
		logic [TIME_W-1:0]  window_sum;
		logic [SPEED_W-1:0] speed;
	} speed_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_data = '0;

	quadrature_encoder_speed_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the speed unit state, advanced once per accepted input transaction.
	logic [TIME_W-1:0] numerator_q;
	logic [TIME_W-1:0] last_edge_q;
	logic [CNT_W-1:0]  edge_cnt_q;
	logic [IDX_W-1:0]  ring_idx_q;
	logic [1:0]        dir_q;
	logic [TIME_W-1:0] win_sum_q;
	logic [TIME_W-1:0] period_ring_q [WINDOW_DEPTH];

	speed_result_t expected_results [$];

	int  error_count = 0;
	int  result_index = 0;
	int  cycle_count = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;
	int  rx_hold_req = 0;
	logic [31:0] stamp_us = '0;

	initial begin
		numerator_q = '0;
		last_edge_q = '0;
		edge_cnt_q = '0;
		ring_idx_q = '0;
		dir_q = DIR_NONE;
		win_sum_q = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) period_ring_q[i] = '0;
	end

	// An edge in the running direction stores the period since the previous edge in the ring;
	// an edge in the other direction instead switches the direction and restarts the window count and sum.
	function automatic void apply_encoder_edge(input logic fwd, input logic [TIME_W-1:0] now);
		logic [1:0] new_dir;
		new_dir = fwd ? DIR_FWD : DIR_BWD;
		if (new_dir != dir_q) begin
			edge_cnt_q = CNT_W'(1);
			dir_q = new_dir;
			win_sum_q = '0;
		end else begin
			ring_idx_q = (ring_idx_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : ring_idx_q + 1'b1;
			// Once the window is full the oldest period drops out before the new one enters.
			if (edge_cnt_q <= CNT_W'(WINDOW_DEPTH))
				edge_cnt_q = edge_cnt_q + 1'b1;
			else
				win_sum_q = win_sum_q - period_ring_q[ring_idx_q];
			period_ring_q[ring_idx_q] = now - last_edge_q;
			win_sum_q = win_sum_q + period_ring_q[ring_idx_q];
		end
		last_edge_q = now;
	endfunction

	// Updates the state for one item and forms the result that the block must return for it.
	function automatic speed_result_t predict_speed_result(input logic [1:0] act, input logic la,
			input logic lb, input logic [TIME_W-1:0] now);
		speed_result_t r;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] divisor;
		logic [TIME_W-1:0] quotient;
		if (act == ACT_EDGE_A)
			apply_encoder_edge(la == lb, now);
		else if (act == ACT_EDGE_B)
			apply_encoder_edge(la != lb, now);
		// The divisor is the longer of the last period and the time since the last edge.
		elapsed = now - last_edge_q;
		divisor = period_ring_q[ring_idx_q];
		if (elapsed > divisor)
			divisor = elapsed;
		if (divisor == '0)
			divisor = TIME_W'(1);
		quotient = numerator_q / divisor;
		r.direction = dir_q;
		r.window_count = (edge_cnt_q > 0) ? 4'(edge_cnt_q - 1'b1) : 4'd0;
		r.window_sum = win_sum_q;
		if (dir_q == DIR_FWD)
			r.speed = {1'b0, quotient};
		else if (dir_q == DIR_BWD)
			r.speed = '0 - {1'b0, quotient};
		else
			r.speed = '0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [SPEED_W-1:0] got,
			input logic [SPEED_W-1:0] want);
		if (error_count < MAX_REPORTS)
			$display("mismatch in result %0d, %s: got %h, expected %h", result_index, what, got,
				want);
		error_count++;
	endtask

	// Offers one input transaction after a random idle gap and records its expected result
	// once the block has taken it. The valid stays high into the next item when no gap follows.
	task automatic send_item(input logic [1:0] act, input logic la, input logic lb,
			input logic [31:0] now);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 17) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, now, lb, la};
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_speed_result(act, la, lb, now));
	endtask

	// Stops offering and waits for every outstanding result; the block is idle afterward.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_numerator(input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= $urandom();
		numerator_q = value;
	endtask

	// Edge spacing: mostly short or moderate periods, sometimes huge ones that wrap the clock.
	function automatic logic [31:0] draw_period();
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom_range(0, 15);
			3, 4, 5, 6: return $urandom_range(16, 5000);
			7, 8: return $urandom_range(5001, 2000000);
			default: return $urandom();
		endcase
	endfunction

	// Runs of edges that agree on a direction, with queries sprinkled in between and a few
	// items of pure noise, so that the window fills, wraps and restarts over and over.
	task automatic send_encoder_traffic(input int n_items);
		int sent;
		int run_len;
		int pick;
		logic fwd;
		logic [1:0] act;
		logic la;
		logic lb;
		sent = 0;
		fwd = 1'($urandom_range(0, 1));
		while (sent < n_items) begin
			run_len = $urandom_range(1, 20);
			if ($urandom_range(0, 1)) fwd = ~fwd;
			repeat (run_len) begin
				pick = $urandom_range(0, 11);
				la = 1'($urandom_range(0, 1));
				if (pick == 0) begin
					// Noise: any action, any levels, any timestamp.
					act = 2'($urandom_range(0, 3));
					lb = 1'($urandom_range(0, 1));
					stamp_us = $urandom();
				end else if (pick <= 2) begin
					act = ($urandom_range(0, 4) == 0) ? ACT_UNUSED : ACT_QUERY;
					lb = 1'($urandom_range(0, 1));
					stamp_us = stamp_us + draw_period();
				end else begin
					act = $urandom_range(0, 1) ? ACT_EDGE_B : ACT_EDGE_A;
					// An A edge is forward when the levels agree, a B edge when they differ.
					if (act == ACT_EDGE_A)
						lb = fwd ? la : ~la;
					else
						lb = fwd ? ~la : la;
					stamp_us = stamp_us + draw_period();
				end
				send_item(act, la, lb, stamp_us);
				sent++;
			end
		end
	endtask

	// Extremes of every field, all four action codes, direction changes, a window that fills
	// and overflows, a zero divisor, wrapping periods and a query long after the last edge.
	task automatic test_directed_cases();
		logic [31:0] t;
		send_item(ACT_QUERY, 1'b0, 1'b0, 32'd0);
		drain_results();
		write_numerator(32'hFFFF_FFFF);
		send_item(ACT_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_item(ACT_QUERY, 1'b1, 1'b0, 32'h0000_0000);
		// The first edge sets forward; with nothing elapsed the divisor falls back to one.
		send_item(ACT_EDGE_A, 1'b0, 1'b0, 32'd100);
		send_item(ACT_EDGE_B, 1'b1, 1'b0, 32'd100);
		send_item(ACT_EDGE_B, 1'b0, 1'b1, 32'hFFFF_FFF0);
		send_item(ACT_EDGE_A, 1'b1, 1'b1, 32'd5);
		for (int k = 0; k < 8; k++) begin
			t = 32'd5 + 32'(k + 1) * 32'd1000;
			if (k % 2)
				send_item(ACT_EDGE_B, k[1], ~k[1], t);
			else
				send_item(ACT_EDGE_A, k[1], k[1], t);
		end
		send_item(ACT_QUERY, 1'b0, 1'b1, 32'h8000_0000 + t);
		t = 32'h8000_2000;
		send_item(ACT_EDGE_A, 1'b1, 1'b0, t);
		send_item(ACT_EDGE_B, 1'b1, 1'b1, t + 32'd300);
		send_item(ACT_EDGE_B, 1'b0, 1'b0, t + 32'd600);
		send_item(ACT_UNUSED, 1'b0, 1'b1, t + 32'd900);
		send_item(ACT_EDGE_A, 1'b0, 1'b0, t + 32'd950);
		send_item(ACT_EDGE_A, 1'b0, 1'b1, t + 32'd951);
		send_item(ACT_QUERY, 1'b1, 1'b1, t + 32'd951);
		drain_results();
		stamp_us = t + 32'd1000;
	endtask

	// Random traffic under several numerator values, written while the block is idle.
	task automatic test_numerator_sweep();
		write_numerator(32'd1);
		send_encoder_traffic(220);
		drain_results();
		write_numerator($urandom());
		send_encoder_traffic(220);
		drain_results();
		write_numerator(32'hFFFF_FFFF);
		send_encoder_traffic(220);
		drain_results();
		write_numerator($urandom_range(0, 65535));
		send_encoder_traffic(180);
		drain_results();
		write_numerator(32'd0);
		send_encoder_traffic(60);
		drain_results();
	endtask

	// The receiver holds off for a long stretch while items keep coming back to back, so the
	// output register fills and the block has to stall its input.
	task automatic test_output_backpressure();
		write_numerator($urandom());
		tx_idle_on = 1'b0;
		rx_hold_req = 400;
		send_encoder_traffic(14);
		drain_results();
		tx_idle_on = 1'b1;
	endtask

	// A stretch with no idling on either side, at the full rate of the block.
	task automatic test_no_idle_stretch();
		write_numerator($urandom());
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_encoder_traffic(120);
		drain_results();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Receiver: before each transaction it waits a random number of cycles, or the long hold-off
	// when one is requested, then raises m_tready until a result is taken.
	always begin
		int stall;
		stall = rx_idle_on ? $urandom_range(0, 17) : 0;
		if (rx_hold_req > 0) begin
			stall = rx_hold_req;
			rx_hold_req = 0;
		end
		repeat (stall) begin
			@(negedge clk);
			m_tready <= 1'b0;
		end
		@(negedge clk);
		m_tready <= 1'b1;
		do @(posedge clk); while (!m_tvalid);
	end

	// Every output transaction is checked field by field against the oldest expectation.
	always @(posedge clk) begin
		speed_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", m_tdata[SPEED_W-1:0], '0);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[1:0] !== want.direction)
					report_mismatch("direction", SPEED_W'(m_tdata[1:0]),
						SPEED_W'(want.direction));
				if (m_tdata[5:2] !== want.window_count)
					report_mismatch("window_count", SPEED_W'(m_tdata[5:2]),
						SPEED_W'(want.window_count));
				if (m_tdata[37:6] !== want.window_sum)
					report_mismatch("window_sum", SPEED_W'(m_tdata[37:6]),
						SPEED_W'(want.window_sum));
				if (m_tdata[70:38] !== want.speed)
					report_mismatch("speed", m_tdata[70:38], want.speed);
			end
			result_index++;
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("quadrature_encoder_speed_unit_test NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_numerator_sweep();
		test_output_backpressure();
		test_no_idle_stretch();
		drain_results();
		// Let any stray output transaction show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results still expected", SPEED_W'(expected_results.size()), '0);
		if (error_count == 0)
			$display("quadrature_encoder_speed_unit_test OK");
		else
			$display("quadrature_encoder_speed_unit_test NOT OK");
		$finish;
	end

endmodule
